// File: rtl/rsa_pkg.sv
// rsa_pkg: shared constants and the sequencer state type of the running
// statistics accumulator. No dependencies.
`default_nettype none
package rsa_pkg;
	localparam int VALUE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam int TIME_BITS_DEF  = 32;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEAN,
		S_MFIX,
		S_SQ,
		S_SCALE,
		S_CROSS,
		S_SUM,
		S_DIV,
		S_ROOT,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

// File: rtl/rsa_mul.sv
// rsa_mul: bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Stand-alone; used by running_stats_accumulator.
`default_nettype none
module rsa_mul #(
	parameter int AW = 97,
	parameter int BW = 33
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [AW-1:0] a,
	input  wire logic [BW-1:0] b,
	output logic               done,
	output logic [AW-1:0]      prod
);
	localparam int CW = $clog2(BW + 1);

	logic [AW-1:0] a_q, acc_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[AW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

// File: rtl/rsa_div.sv
// rsa_div: restoring bit-serial divider, one quotient bit per cycle, with a
// loadable iteration count. Stand-alone; used by running_stats_accumulator.
`default_nettype none
module rsa_div #(
	parameter int NW = 97,
	parameter int DW = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [$clog2(NW+1)-1:0] iters,
	input  wire logic [NW-1:0]           num,
	input  wire logic [DW-1:0]           den,
	output logic                         done,
	output logic [NW-1:0]                quo,
	output logic [DW-1:0]                rem
);
	localparam int IW = $clog2(NW + 1);

	logic [NW-1:0] num_q, quo_q;
	logic [DW-1:0] den_q, rem_q;
	logic [IW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial;
	logic          take;

	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		take  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], take};
			rem_q <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// File: rtl/rsa_sqrt.sv
// rsa_sqrt: digit-by-digit floor square root, two radicand bits per cycle,
// saturating at all ones. Stand-alone; used by running_stats_accumulator.
`default_nettype none
module rsa_sqrt #(
	parameter int NW = 97,
	parameter int VB = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] val,
	output logic               done,
	output logic [VB-1:0]      root
);
	localparam int CW = $clog2(VB + 1);
	localparam int RW = VB + 3;

	logic [2*VB-1:0] v_q;
	logic [VB-1:0]   root_q;
	logic [RW-1:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q, done_q, sat_q;
	logic [RW-1:0]   nxt, trial;
	logic            take;

	always_comb begin
		nxt   = {rem_q[VB:0], v_q[2*VB-1:2*VB-2]};
		trial = {1'b0, root_q, 2'b01};
		take  = (nxt >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= val[2*VB-1:0];
			sat_q  <= (val[NW-1:2*VB] != '0);
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[2*VB-3:0], 2'b00};
			root_q <= {root_q[VB-2:0], take};
			rem_q  <= take ? nxt - trial : nxt;
		end
	end

	assign done = done_q;
	assign root = sat_q ? '1 : root_q;
endmodule
`default_nettype wire

// File: rtl/running_stats_accumulator.sv
// running_stats_accumulator: top level, sequencer and statistics registers.
// Depends on rsa_pkg, rsa_mul, rsa_div and rsa_sqrt.
//
// Each transaction on the s_ side either adds a sample (tuser 0) or clears all
// statistics (tuser 1) and yields one transaction on the m_ side carrying the
// count, time span, min, max, mean and population standard deviation. A clear
// goes straight from idle to the output state; an add runs the bit-serial
// divider for the mean, three serial multiplications, the serial variance
// division and the serial square root before the output state. One item is
// processed at a time; a new item is taken while a finished result still
// waits on the m_ side, and the next result holds the sequencer until the
// waiting one is taken.
`default_nettype none
module running_stats_accumulator #(
	parameter int VALUE_BITS = rsa_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = rsa_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF,
	parameter int TIME_BITS  = rsa_pkg::TIME_BITS_DEF,
	localparam int IN_W  = ((VALUE_BITS + TIME_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((COUNT_BITS + 2*TIME_BITS + 4*VALUE_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// sample_value, sample_time
	input  wire logic [IN_W-1:0]  s_tdata,
	// opcode
	input  wire logic             s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// entry_count, time_first, time_last, value_min, value_max, mean_out,
	// deviation_out
	output logic [OUT_W-1:0]      m_tdata
);
	localparam int VB = VALUE_BITS;
	localparam int CB = COUNT_BITS;
	localparam int TB = TIME_BITS;
	localparam int NW = 2*VB + CB + 1;
	localparam int MB = (VB + 1 > CB) ? VB + 1 : CB;
	localparam int IW = $clog2(NW + 1);
	localparam int PAD = OUT_W - (CB + 2*TB + 4*VB);
	// binary point of mean and deviation needs no scaling
	localparam int FB_UNUSED = FRAC_BITS;

	rsa_pkg::state_t state_q, state_d;

	logic [CB-1:0] cnt_q;
	logic [TB-1:0] tfirst_q, tlast_q;
	logic signed [VB-1:0] min_q, max_q, mean_q, oldm_q, x_q;
	logic [VB-1:0] dev_q;
	logic          dneg_q;
	logic [VB:0]   absn_q, abso_q;
	logic [NW-1:0] prod_q, num_q;

	logic [TB-1:0] r_tfirst_q, r_tlast_q;
	logic signed [VB-1:0] r_min_q, r_max_q, r_mean_q;
	logic [VB-1:0] r_dev_q;
	logic [CB-1:0] r_cnt_q;
	logic          mvalid_q;

	logic accept, out_free;
	logic signed [VB-1:0] in_x;
	logic [TB-1:0] in_t;
	logic signed [VB:0] in_d;
	logic [VB:0]   in_mag;

	logic          mul_start, mul_done;
	logic [NW-1:0] mul_a, mul_p;
	logic [MB-1:0] mul_b;
	logic          div_start, div_done;
	logic [IW-1:0] div_iters;
	logic [NW-1:0] div_num, div_quo;
	logic [CB-1:0] div_den;
	logic [CB-1:0] div_rem;
	logic          sqrt_start, sqrt_done;
	logic [VB-1:0] sqrt_root;

	logic signed [VB+1:0] q_s, newm_w;
	logic signed [VB:0]   dn, dold;

	assign in_x     = s_tdata[VB-1:0];
	assign in_t     = s_tdata[VB+TB-1:VB];
	assign s_tready = (state_q == rsa_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !mvalid_q || m_tready;
	assign in_d     = {in_x[VB-1], in_x} - {mean_q[VB-1], mean_q};
	assign in_mag   = in_d[VB] ? (VB+1)'(-in_d) : in_d;
	// divide the mean step by the count that includes this sample
	assign div_den  = (state_q == rsa_pkg::S_IDLE && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

	// fix floor quotient up to truncation toward zero
	always_comb begin
		q_s    = dneg_q ? -{1'b0, div_quo[VB:0]} - (VB+2)'(div_rem != '0)
		                : {1'b0, div_quo[VB:0]};
		newm_w = {{2{oldm_q[VB-1]}}, oldm_q} + q_s;
		if (newm_w[VB+1] && (div_rem != '0)) newm_w = newm_w + 1'b1;
		dn   = {x_q[VB-1], x_q} - newm_w[VB:0];
		dold = {x_q[VB-1], x_q} - {oldm_q[VB-1], oldm_q};
	end

	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		mul_a      = NW'(dev_q);
		mul_b      = MB'(dev_q);
		div_num    = num_q;
		div_iters  = IW'(NW);
		case (state_q)
			rsa_pkg::S_IDLE: begin
				div_num   = {in_mag, {(NW-VB-1){1'b0}}};
				div_iters = IW'(VB + 1);
				if (accept) begin
					if (s_tuser) begin
						state_d = rsa_pkg::S_OUT;
					end else begin
						div_start = 1'b1;
						state_d   = rsa_pkg::S_MEAN;
					end
				end
			end
			rsa_pkg::S_MEAN: if (div_done) state_d = rsa_pkg::S_MFIX;
			rsa_pkg::S_MFIX: begin
				mul_start = 1'b1;
				state_d   = rsa_pkg::S_SQ;
			end
			rsa_pkg::S_SQ: begin
				mul_a = mul_p;
				mul_b = MB'(cnt_q - 1'b1);
				if (mul_done) begin
					mul_start = 1'b1;
					state_d   = rsa_pkg::S_SCALE;
				end
			end
			rsa_pkg::S_SCALE: begin
				mul_a = NW'(absn_q);
				mul_b = MB'(abso_q);
				if (mul_done) begin
					mul_start = 1'b1;
					state_d   = rsa_pkg::S_CROSS;
				end
			end
			rsa_pkg::S_CROSS: if (mul_done) state_d = rsa_pkg::S_SUM;
			rsa_pkg::S_SUM: begin
				div_start = 1'b1;
				state_d   = rsa_pkg::S_DIV;
			end
			rsa_pkg::S_DIV: if (div_done) begin
				sqrt_start = 1'b1;
				state_d    = rsa_pkg::S_ROOT;
			end
			rsa_pkg::S_ROOT: if (sqrt_done) state_d = rsa_pkg::S_OUT;
			rsa_pkg::S_OUT: if (out_free) state_d = rsa_pkg::S_IDLE;
			default: state_d = rsa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rsa_pkg::S_IDLE;
			mvalid_q <= 1'b0;
			cnt_q    <= '0;
			tfirst_q <= '0;
			tlast_q  <= '0;
			min_q    <= '0;
			max_q    <= '0;
			mean_q   <= '0;
			dev_q    <= '0;
		end else begin
			state_q  <= state_d;
			mvalid_q <= (state_q == rsa_pkg::S_OUT && out_free) ? 1'b1
			                                                   : (mvalid_q && !m_tready);
			if (accept) begin
				if (s_tuser) begin
					cnt_q    <= '0;
					tfirst_q <= '0;
					tlast_q  <= '0;
					min_q    <= '0;
					max_q    <= '0;
					mean_q   <= '0;
					dev_q    <= '0;
				end else begin
					if (cnt_q == '0) begin
						tfirst_q <= in_t;
						tlast_q  <= in_t;
						min_q    <= in_x;
						max_q    <= in_x;
					end else begin
						if (in_t < tfirst_q) tfirst_q <= in_t;
						if (in_t > tlast_q)  tlast_q  <= in_t;
						if (in_x < min_q)    min_q    <= in_x;
						if (in_x > max_q)    max_q    <= in_x;
					end
					if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == rsa_pkg::S_MFIX) mean_q <= newm_w[VB-1:0];
			if (state_q == rsa_pkg::S_ROOT && sqrt_done) dev_q <= sqrt_root;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_x;
			oldm_q <= mean_q;
			dneg_q <= in_d[VB];
		end
		if (state_q == rsa_pkg::S_MFIX) begin
			absn_q <= dn[VB] ? (VB+1)'(-dn) : dn;
			abso_q <= dold[VB] ? (VB+1)'(-dold) : dold;
		end
		if (state_q == rsa_pkg::S_SCALE && mul_done) prod_q <= mul_p;
		if (state_q == rsa_pkg::S_CROSS && mul_done) num_q <= prod_q + mul_p;
		if (state_q == rsa_pkg::S_OUT && out_free) begin
			r_cnt_q    <= cnt_q;
			r_tfirst_q <= tfirst_q;
			r_tlast_q  <= tlast_q;
			r_min_q    <= min_q;
			r_max_q    <= max_q;
			r_mean_q   <= mean_q;
			r_dev_q    <= dev_q;
		end
	end

	rsa_mul #(.AW(NW), .BW(MB)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	rsa_div #(.NW(NW), .DW(CB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .iters(div_iters),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	rsa_sqrt #(.NW(NW), .VB(VB)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .val(div_quo),
		.done(sqrt_done), .root(sqrt_root)
	);

	assign m_tvalid = mvalid_q;
	generate
		if (PAD > 0) begin : g_pad
			assign m_tdata = {{PAD{1'b0}}, r_dev_q, r_mean_q, r_max_q, r_min_q,
			                  r_tlast_q, r_tfirst_q, r_cnt_q};
		end else begin : g_nopad
			assign m_tdata = {r_dev_q, r_mean_q, r_max_q, r_min_q,
			                  r_tlast_q, r_tfirst_q, r_cnt_q};
		end
	endgenerate
endmodule
`default_nettype wire

// File: verif/running_stats_checker.sv
// running_stats_checker: watches both stream channels of the running statistics
// accumulator, predicts each result and compares it. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module running_stats_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [63:0]  s_tdata,
	input  wire logic         s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [223:0] m_tdata,
	output int                fail_count,
	output int                pending
);
	localparam logic OP_ADD = 1'b0;

	typedef struct packed {
		logic [31:0] deviation;
		logic [31:0] mean;
		logic [31:0] vmax;
		logic [31:0] vmin;
		logic [31:0] t_last;
		logic [31:0] t_first;
		logic [31:0] count;
	} stats_t;

	stats_t stats;
	stats_t stats_queue[$];

	// Floor square root of the variance numerator divided by n.
	function automatic logic [31:0] next_deviation(logic [31:0] sd, logic signed [31:0] x,
			logic signed [31:0] mean_before, logic signed [31:0] mean_after, logic [31:0] n);
		logic [127:0] num;
		logic [127:0] quot;
		logic [63:0] da, db;
		logic [31:0] root;
		logic [31:0] cand;
		da = 64'(longint'(x) - longint'(mean_after));
		db = 64'(longint'(x) - longint'(mean_before));
		if (da[63]) da = -da;
		if (db[63]) db = -db;
		num = 128'(sd) * 128'(sd) * 128'(n - 32'd1) + 128'(da) * 128'(db);
		quot = num / 128'(n);
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (32'd1 << b);
			if (128'(64'(cand) * 64'(cand)) <= quot) root = cand;
		end
		return root;
	endfunction

	function automatic stats_t fold_sample(stats_t st, logic op, logic signed [31:0] x,
			logic [31:0] tm);
		stats_t nx;
		longint d, q, old_m, new_m;
		if (op != OP_ADD) return '0;
		nx = st;
		old_m = longint'($signed(st.mean));
		if (st.count == 0) begin
			nx.t_first = tm;
			nx.t_last = tm;
			nx.vmin = x;
			nx.vmax = x;
		end else begin
			if (tm < st.t_first) nx.t_first = tm;
			if (tm > st.t_last) nx.t_last = tm;
			if (x < $signed(st.vmin)) nx.vmin = x;
			if (x > $signed(st.vmax)) nx.vmax = x;
		end
		if (st.count != 32'hffff_ffff) nx.count = st.count + 1;
		d = longint'(x) - old_m;
		// SV division already truncates toward zero on the step; fix to match a
		// truncation of the whole mean instead
		q = d / longint'({32'd0, nx.count});
		if (d % longint'({32'd0, nx.count}) != 0 && d < 0) q = q - 1;
		new_m = old_m + q;
		if (new_m < 0 && d % longint'({32'd0, nx.count}) != 0) new_m = new_m + 1;
		nx.mean = new_m[31:0];
		nx.deviation = next_deviation(st.deviation, x, old_m[31:0], new_m[31:0], nx.count);
		return nx;
	endfunction

	assign pending = stats_queue.size();

	always @(posedge clk or negedge arst_n) begin
		stats_t got, want;
		if (!arst_n) begin
			stats <= '0;
			fail_count <= 0;
			stats_queue.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				want = fold_sample(stats, s_tuser, s_tdata[31:0], s_tdata[63:32]);
				stats <= want;
				stats_queue.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (stats_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = stats_queue.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected cnt=%h tf=%h tl=%h min=%h max=%h mean=%h sd=%h, got cnt=%h tf=%h tl=%h min=%h max=%h mean=%h sd=%h",
								want.count, want.t_first, want.t_last, want.vmin, want.vmax,
								want.mean, want.deviation, got.count, got.t_first, got.t_last,
								got.vmin, got.vmax, got.mean, got.deviation);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: verif/running_stats_accumulator_test.sv
// running_stats_accumulator_test: clock, reset, stimulus and verdict for the
// running statistics accumulator. Depends on running_stats_accumulator and running_stats_checker.
`timescale 1ns / 1ps
`default_nettype none
module running_stats_accumulator_test;
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [223:0] m_tdata;
	int fail_count, pending;
	int send_idle = 0, recv_stall = 0;
	int hold_count = 0;
	bit hold_off = 1'b0;
	longint cycles = 0;

	running_stats_accumulator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	running_stats_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[running_stats_accumulator] ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off counted here on request
	always @(negedge clk) begin
		if (hold_off && hold_count < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
		end else m_tready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_item(logic op, logic [31:0] val, logic [31:0] tm);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {tm, val};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7fff_ffff - $urandom_range(3);
			2: return $urandom_range(200) - 100;
			3: return $urandom_range(32'h000f_ffff) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] base;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: empty state, extremes, clears, first entry after clear
		send_item(OP_CLEAR, 32'h0, 32'h0);
		send_item(OP_ADD, 32'h7fff_ffff, 32'hffff_ffff);
		send_item(OP_ADD, 32'h8000_0000, 32'h0);
		send_item(OP_ADD, 32'h7fff_ffff, 32'h8000_0000);
		send_item(OP_ADD, 32'h8000_0000, 32'h7fff_ffff);
		send_item(OP_ADD, 32'h0, 32'h1);
		send_item(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
		send_item(OP_ADD, 32'hffff_ffff, 32'h10);
		send_item(OP_ADD, 32'h0000_0001, 32'h5);
		send_item(OP_ADD, 32'hffff_fffe, 32'h20);
		send_item(OP_ADD, 32'h0001_0000, 32'h20);
		send_item(OP_CLEAR, 32'h0, 32'h0);
		send_item(OP_ADD, 32'h0, 32'h0);
		send_item(OP_ADD, 32'h0, 32'h0);
		drain_results();
		// sender pause until every result is in, then a long receiver hold-off
		// while the sender keeps offering, so the input stalls
		hold_off = 1'b1;
		for (int i = 0; i < 6; i++) send_item(OP_ADD, pick_value(), $urandom);
		drain_results();
		hold_off = 1'b0;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1 || phase == 3) ? 69 : 0;
			recv_stall = (phase == 2) ? 69 : (phase == 3 ? 9 : 0);
			if (phase == 3) send_idle = 9;
			base = $urandom;
			for (int i = 0; i < 260; i++) begin
				if ($urandom_range(39) == 0) send_item(OP_CLEAR, $urandom, $urandom);
				else send_item(OP_ADD, pick_value(),
					($urandom_range(3) == 0) ? $urandom : base + $urandom_range(1000));
			end
		end
		send_idle = 0;
		recv_stall = 0;
		drain_results();
		repeat (400) @(negedge clk);
		if (fail_count == 0) $display("[running_stats_accumulator] OK");
		else $display("[running_stats_accumulator] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
rtl/rsa_pkg.sv
rtl/rsa_mul.sv
rtl/rsa_div.sv
rtl/rsa_sqrt.sv
rtl/running_stats_accumulator.sv
verif/running_stats_checker.sv
verif/running_stats_accumulator_test.sv
